// ===== rtl/cnv3_pkg.sv =====
// cnv3_pkg: shared widths, defaults and register codes of the 3x3 rgba convolver
// used by the stream interfaces and by conv3x3_rgba_clamp; no dependencies
package cnv3_pkg;

  localparam int PIX_W       = 8;
  localparam int WORD_W      = 4 * PIX_W;
  localparam int WEIGHT_W    = 16;
  localparam int KROW_W      = 3 * WEIGHT_W;
  localparam int GEOM_W      = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = KROW_W;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam logic [KROW_W-1:0] KROW_TOP_RST = KROW_W'(0);
  localparam logic [KROW_W-1:0] KROW_MID_RST = KROW_W'(256);
  localparam logic [KROW_W-1:0] KROW_BOT_RST = KROW_W'(0);
  localparam logic [GEOM_W-1:0] WIDTH_RST    = GEOM_W'(2048);
  localparam logic [GEOM_W-1:0] HEIGHT_RST   = GEOM_W'(2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MID    = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_IMAGE_HEIGHT  = 3'd4
  } reg_idx_t;

endpackage

// ===== rtl/cnv3_in_if.sv =====
// cnv3_in_if: valid/ready channel carrying one rgba input pixel
// depends on cnv3_pkg for the channel width
interface cnv3_in_if;
  logic                      valid;
  logic                      ready;
  logic [cnv3_pkg::PIX_W-1:0] in_red;
  logic [cnv3_pkg::PIX_W-1:0] in_green;
  logic [cnv3_pkg::PIX_W-1:0] in_blue;
  logic [cnv3_pkg::PIX_W-1:0] in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  input in_alpha, output ready);
endinterface

// ===== rtl/cnv3_out_if.sv =====
// cnv3_out_if: valid/ready channel carrying one convolved rgba pixel and frame flag
// depends on cnv3_pkg for the channel width
interface cnv3_out_if;
  logic                      valid;
  logic                      ready;
  logic [cnv3_pkg::PIX_W-1:0] out_red;
  logic [cnv3_pkg::PIX_W-1:0] out_green;
  logic [cnv3_pkg::PIX_W-1:0] out_blue;
  logic [cnv3_pkg::PIX_W-1:0] out_alpha;
  logic                      frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, input frame_end, output ready);
endinterface

// ===== rtl/conv3x3_rgba_clamp.sv =====
// conv3x3_rgba_clamp: streaming 3x3 convolution over rgba pixels with a line memory
// depends on cnv3_pkg, cnv3_in_if and cnv3_out_if
//
//   channel  direction  request moves
//   in_s     sink       one rgba pixel in raster order
//   out_s    source     one valid-region pixel, frame_end on the last of a frame
//   cfg_*    input      one register write, no wait, no read-back
//
// one pixel per cycle sustained while out_s.ready holds; the line memory is read at
// accept and written back when that pixel moves on from stage 1
// reset clears the pipeline, counters, window and registers; the line memory
// has no clearing pass and keeps its contents
// a stalled output stops only the stages that are full; bubbles still fill
module conv3x3_rgba_clamp #(
  parameter int MAX_WIDTH  = cnv3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cnv3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cnv3_in_if.sink                         in_s,
  cnv3_out_if.source                      out_s,
  input  logic                            cfg_we,
  input  logic [cnv3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cnv3_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = cnv3_pkg::PIX_W;
  localparam int DW  = cnv3_pkg::WORD_W;
  localparam int KW  = cnv3_pkg::WEIGHT_W;
  localparam int PRW = PW + 1 + KW;
  localparam int RSW = PRW + 2;
  localparam int TSW = RSW + 2;

  // configuration
  logic [cnv3_pkg::KROW_W-1:0] krow_r [3];
  logic [cnv3_pkg::GEOM_W-1:0] width_r, height_r;
  logic                        geom_wr;

  assign geom_wr = cfg_we && (cfg_index == cnv3_pkg::REG_IMAGE_WIDTH ||
                              cfg_index == cnv3_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krow_r[0] <= cnv3_pkg::KROW_TOP_RST;
      krow_r[1] <= cnv3_pkg::KROW_MID_RST;
      krow_r[2] <= cnv3_pkg::KROW_BOT_RST;
      width_r   <= cnv3_pkg::WIDTH_RST;
      height_r  <= cnv3_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cnv3_pkg::REG_KERNEL_TOP:    krow_r[0] <= cfg_data;
        cnv3_pkg::REG_KERNEL_MID:    krow_r[1] <= cfg_data;
        cnv3_pkg::REG_KERNEL_BOTTOM: krow_r[2] <= cfg_data;
        cnv3_pkg::REG_IMAGE_WIDTH:   width_r   <= cfg_data[cnv3_pkg::GEOM_W-1:0];
        cnv3_pkg::REG_IMAGE_HEIGHT:  height_r  <= cfg_data[cnv3_pkg::GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated geometry
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (32'(width_r) < 32'd3)
      w_eff = WW'(3);
    else if (32'(width_r) > 32'(MAX_WIDTH))
      w_eff = WW'(MAX_WIDTH);
    else
      w_eff = WW'(width_r);
    if (32'(height_r) < 32'd3)
      h_eff = HW'(3);
    else if (32'(height_r) > 32'(MAX_HEIGHT))
      h_eff = HW'(MAX_HEIGHT);
    else
      h_eff = HW'(height_r);
  end

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic go1, go2, go3, go4, in_acc, s1_move;

  assign go4     = !out_valid_r || out_s.ready;
  assign go3     = !v4_r || go4;
  assign go2     = !v3_r || go3;
  assign go1     = !v2_r || go2;
  assign in_s.ready = !v1_r || go1;
  assign in_acc  = in_s.valid && in_s.ready;
  assign s1_move = v1_r && go1;

  // position counters
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          col_last, row_last, emit;

  assign col_last = WW'(col_r) == w_eff - WW'(1);
  assign row_last = HW'(row_r) == h_eff - HW'(1);
  assign emit     = (col_r >= CW'(2)) && (row_r >= RW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (geom_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line memory: entry c holds {one row up, two rows up} of column c
  logic [2*DW-1:0] line_mem [MAX_WIDTH];
  logic [2*DW-1:0] rd_r;
  logic [DW-1:0]   in_px;
  logic [DW-1:0]   s1_px_r;
  logic [CW-1:0]   s1_col_r;
  logic            s1_emit_r, s1_fe_r;

  assign in_px = {in_s.in_alpha, in_s.in_blue, in_s.in_green, in_s.in_red};

  always_ff @(posedge clk) begin
    if (in_acc)
      rd_r <= line_mem[col_r];
    if (s1_move)
      line_mem[s1_col_r] <= {s1_px_r, rd_r[2*DW-1:DW]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      v1_r <= 1'b0;
    else if (in_s.ready)
      v1_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_px;
      s1_col_r  <= col_r;
      s1_emit_r <= emit;
      s1_fe_r   <= col_last && row_last;
    end
  end

  // window, row-major, top-left first
  logic [DW-1:0] win_r [9];
  logic          s2_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++)
        win_r[i] <= '0;
    end else if (s1_move) begin
      for (int r = 0; r < 3; r++) begin
        win_r[3*r]   <= win_r[3*r+1];
        win_r[3*r+1] <= win_r[3*r+2];
      end
      win_r[2] <= rd_r[DW-1:0];
      win_r[5] <= rd_r[2*DW-1:DW];
      win_r[8] <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      v2_r <= 1'b0;
    else if (go1)
      v2_r <= v1_r && s1_emit_r;
  end

  always_ff @(posedge clk) begin
    if (go1)
      s2_fe_r <= s1_fe_r;
  end

  // products
  logic signed [KW-1:0]  wt [9];
  logic signed [PRW-1:0] prod_r [3][9];
  logic [PW-1:0]         s3_alpha_r, s4_alpha_r;
  logic                  s3_fe_r, s4_fe_r;

  always_comb begin
    for (int t = 0; t < 9; t++)
      wt[t] = $signed(krow_r[t/3][KW*(t%3) +: KW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      v3_r <= 1'b0;
    else if (go2)
      v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      for (int ch = 0; ch < 3; ch++)
        for (int t = 0; t < 9; t++)
          prod_r[ch][t] <= $signed({1'b0, win_r[t][PW*ch +: PW]}) * wt[t];
      s3_alpha_r <= win_r[4][DW-1 -: PW];
      s3_fe_r    <= s2_fe_r;
    end
  end

  // row sums
  logic signed [RSW-1:0] rsum_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n)
      v4_r <= 1'b0;
    else if (go3)
      v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      for (int ch = 0; ch < 3; ch++)
        for (int r = 0; r < 3; r++)
          rsum_r[ch][r] <= RSW'(prod_r[ch][3*r]) + RSW'(prod_r[ch][3*r+1])
                         + RSW'(prod_r[ch][3*r+2]);
      s4_alpha_r <= s3_alpha_r;
      s4_fe_r    <= s3_fe_r;
    end
  end

  // total, clamp and output register
  logic signed [TSW-1:0] tot [3];
  logic [PW-1:0]         clamped [3];
  logic [PW-1:0]         out_ch_r [3];
  logic [PW-1:0]         out_alpha_r;
  logic                  out_fe_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = TSW'(rsum_r[ch][0]) + TSW'(rsum_r[ch][1]) + TSW'(rsum_r[ch][2]);
      if (tot[ch][TSW-1])
        clamped[ch] = '0;
      else if (|tot[ch][TSW-2:2*PW])
        clamped[ch] = '1;
      else
        clamped[ch] = tot[ch][2*PW-1:PW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (go4)
      out_valid_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (go4) begin
      for (int ch = 0; ch < 3; ch++)
        out_ch_r[ch] <= clamped[ch];
      out_alpha_r <= s4_alpha_r;
      out_fe_r    <= s4_fe_r;
    end
  end

  assign out_s.valid     = out_valid_r;
  assign out_s.out_red   = out_ch_r[0];
  assign out_s.out_green = out_ch_r[1];
  assign out_s.out_blue  = out_ch_r[2];
  assign out_s.out_alpha = out_alpha_r;
  assign out_s.frame_end = out_fe_r;

  // checks
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_move) |-> (col_r != s1_col_r))
    else $error("line memory read and write hit the same column");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w_eff)
    else $error("column counter beyond row width");

  a_geom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    geom_wr |=> (col_r == '0 && row_r == '0))
    else $error("geometry write did not restart the frame");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !go4) |=> (v4_r && $stable(s4_fe_r) && $stable(s4_alpha_r)))
    else $error("sum stage lost its pixel during a stall");

endmodule

// ===== bench/conv3x3_rgba_clamp_checker.sv =====
`timescale 1ns / 1ps
// conv3x3_rgba_clamp_checker: watches the pixel channels and the register port of the
// convolver, predicts every filtered pixel and compares it with the one the block sends
// depends on cnv3_pkg, cnv3_in_if and cnv3_out_if
module conv3x3_rgba_clamp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  cnv3_in_if                              in_mon,
  cnv3_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [cnv3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cnv3_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     due_count,
  output int unsigned                     checked_count
);

  localparam int PIX_W      = cnv3_pkg::PIX_W;
  localparam int WORD_W     = cnv3_pkg::WORD_W;
  localparam int WEIGHT_W   = cnv3_pkg::WEIGHT_W;
  localparam int KROW_W     = cnv3_pkg::KROW_W;
  localparam int GEOM_W     = cnv3_pkg::GEOM_W;
  localparam int LINE_W     = cnv3_pkg::MAX_WIDTH_DEF;
  localparam int FRAC_W     = 8;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [PIX_W-1:0] red, green, blue, alpha;
    logic             frame_end;
  } conv_pixel_t;

  logic [WORD_W-1:0] line_mem [2*LINE_W];
  logic [WORD_W-1:0] win [9];
  logic [KROW_W-1:0] kern [3];
  logic [GEOM_W-1:0] width_reg, height_reg;
  int unsigned       col_pos, row_pos, bad, seen;
  conv_pixel_t       conv_pixels_due [$];

  initial foreach (line_mem[i]) line_mem[i] = '0;

  function automatic int unsigned clamp_geom(logic [GEOM_W-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [PIX_W-1:0] filtered_channel(int lane);
    int acc, r, c;
    acc = 0;
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        acc += int'(win[3*r+c][PIX_W*lane +: PIX_W])
             * int'($signed(kern[r][WEIGHT_W*c +: WEIGHT_W]));
    if (acc < 0) return '0;
    if ((acc >>> FRAC_W) > 255) return '1;
    return PIX_W'(acc >>> FRAC_W);
  endfunction

  always @(posedge clk) begin
    int unsigned       w_eff, h_eff, col, row, r;
    logic [WORD_W-1:0] px, up2, up1;
    conv_pixel_t       got, want, res;
    if (!rst_n) begin
      kern[0]    = cnv3_pkg::KROW_TOP_RST;
      kern[1]    = cnv3_pkg::KROW_MID_RST;
      kern[2]    = cnv3_pkg::KROW_BOT_RST;
      width_reg  = cnv3_pkg::WIDTH_RST;
      height_reg = cnv3_pkg::HEIGHT_RST;
      for (r = 0; r < 9; r++) win[r] = '0;
      col_pos = 0;
      row_pos = 0;
      bad     = 0;
      seen    = 0;
      conv_pixels_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.out_red, out_mon.out_green, out_mon.out_blue, out_mon.out_alpha,
               out_mon.frame_end};
        seen++;
        if (conv_pixels_due.size() == 0) begin
          bad++;
          if (bad <= REPORT_MAX)
            $display("unexpected pixel r=%02h g=%02h b=%02h a=%02h end=%0b",
                     got.red, got.green, got.blue, got.alpha, got.frame_end);
        end else begin
          want = conv_pixels_due.pop_front();
          if (got !== want) begin
            bad++;
            if (bad <= REPORT_MAX) begin
              $display("pixel %0d: expected r=%02h g=%02h b=%02h a=%02h end=%0b",
                       seen, want.red, want.green, want.blue, want.alpha, want.frame_end);
              $display("pixel %0d: got      r=%02h g=%02h b=%02h a=%02h end=%0b",
                       seen, got.red, got.green, got.blue, got.alpha, got.frame_end);
            end
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          cnv3_pkg::REG_KERNEL_TOP:    kern[0] = cfg_data[KROW_W-1:0];
          cnv3_pkg::REG_KERNEL_MID:    kern[1] = cfg_data[KROW_W-1:0];
          cnv3_pkg::REG_KERNEL_BOTTOM: kern[2] = cfg_data[KROW_W-1:0];
          cnv3_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[GEOM_W-1:0];
            col_pos   = 0;
            row_pos   = 0;
          end
          cnv3_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[GEOM_W-1:0];
            col_pos    = 0;
            row_pos    = 0;
          end
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        w_eff = clamp_geom(width_reg, cnv3_pkg::MAX_WIDTH_DEF);
        h_eff = clamp_geom(height_reg, cnv3_pkg::MAX_HEIGHT_DEF);
        col   = (col_pos >= LINE_W) ? 0 : col_pos;
        row   = row_pos;
        px    = {in_mon.in_alpha, in_mon.in_blue, in_mon.in_green, in_mon.in_red};
        up2   = line_mem[col];
        up1   = line_mem[LINE_W + col];
        line_mem[col]          = up1;
        line_mem[LINE_W + col] = px;
        for (r = 0; r < 3; r++) begin
          win[3*r]   = win[3*r+1];
          win[3*r+1] = win[3*r+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = px;
        if (row >= 2 && col >= 2) begin
          res.red       = filtered_channel(0);
          res.green     = filtered_channel(1);
          res.blue      = filtered_channel(2);
          res.alpha     = win[4][3*PIX_W +: PIX_W];
          res.frame_end = (row == h_eff - 1) && (col == w_eff - 1);
          conv_pixels_due.push_back(res);
        end
        if (col + 1 >= w_eff) begin
          col_pos = 0;
          row_pos = (row + 1 >= h_eff) ? 0 : row + 1;
        end else begin
          col_pos = col + 1;
          row_pos = row;
        end
      end
    end
    fail_count    <= bad;
    due_count     <= conv_pixels_due.size();
    checked_count <= seen;
  end

endmodule

// ===== bench/conv3x3_rgba_clamp_tb.sv =====
`timescale 1ns / 1ps
// conv3x3_rgba_clamp_tb: streams rgba frames and register writes into conv3x3_rgba_clamp
// with random idling on both channels and reports the verdict of the checker beside it
// depends on cnv3_pkg, cnv3_in_if, cnv3_out_if, conv3x3_rgba_clamp_checker and the block
module conv3x3_rgba_clamp_tb;

  localparam int PIX_W        = cnv3_pkg::PIX_W;
  localparam int WORD_W       = cnv3_pkg::WORD_W;
  localparam int WEIGHT_W     = cnv3_pkg::WEIGHT_W;
  localparam int KROW_W       = cnv3_pkg::KROW_W;
  localparam int GEOM_W       = cnv3_pkg::GEOM_W;
  localparam int CFG_IDX_W    = cnv3_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = cnv3_pkg::CFG_DATA_W;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int WIDE_PHASE   = 3;
  localparam int GEOM_MAX_RAW = (1 << GEOM_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(5);
  localparam int SPARE_COUNT  = 3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_total, due_total, checked_total;
  int unsigned           in_idle_pct = 12;
  int unsigned           out_idle_pct = 12;
  int unsigned           stim_width, stim_height, pixels_sent;
  int unsigned           cycle_count = 0;

  cnv3_in_if  in_if ();
  cnv3_out_if out_if ();

  conv3x3_rgba_clamp dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  conv3x3_rgba_clamp_checker conv_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_total),
    .due_count     (due_total),
    .checked_count (checked_total)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == cnv3_pkg::REG_IMAGE_WIDTH)
      stim_width = (data[GEOM_W-1:0] < 3) ? 3 :
                   (data[GEOM_W-1:0] > cnv3_pkg::MAX_WIDTH_DEF) ? cnv3_pkg::MAX_WIDTH_DEF :
                   data[GEOM_W-1:0];
    if (idx == cnv3_pkg::REG_IMAGE_HEIGHT)
      stim_height = (data[GEOM_W-1:0] < 3) ? 3 :
                    (data[GEOM_W-1:0] > cnv3_pkg::MAX_HEIGHT_DEF) ? cnv3_pkg::MAX_HEIGHT_DEF :
                    data[GEOM_W-1:0];
  endtask

  task automatic send_pixel(input logic [WORD_W-1:0] px);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.in_red   <= px[0 +: PIX_W];
    in_if.in_green <= px[PIX_W +: PIX_W];
    in_if.in_blue  <= px[2*PIX_W +: PIX_W];
    in_if.in_alpha <= px[3*PIX_W +: PIX_W];
    do @(posedge clk); while (!in_if.ready);
    pixels_sent++;
  endtask

  // drop valid in the step of the last request, then wait out the pipeline
  task automatic finish_burst();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (due_total != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] geom_word(int unsigned v);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom_range(0, 1) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
    word[GEOM_W-1:0] = GEOM_W'(v);
    return word;
  endfunction

  initial begin
    int unsigned         phase, k, t, n, i, geom_pick, random_sent;
    logic [WEIGHT_W-1:0] tap;
    logic [KROW_W-1:0]   krow;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= cnv3_pkg::REG_KERNEL_TOP;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.in_red   <= '0;
    in_if.in_green <= '0;
    in_if.in_blue  <= '0;
    in_if.in_alpha <= '0;
    stim_width  = cnv3_pkg::WIDTH_RST;
    stim_height = cnv3_pkg::HEIGHT_RST;
    pixels_sent = 0;
    random_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // center tap at 1.0 passes the center pixel through
    cfg_write(cnv3_pkg::REG_KERNEL_TOP, '0);
    cfg_write(cnv3_pkg::REG_KERNEL_MID, CFG_DATA_W'(48'h0000_0100_0000));
    cfg_write(cnv3_pkg::REG_KERNEL_BOTTOM, '0);
    cfg_write(cnv3_pkg::REG_IMAGE_WIDTH, geom_word(3));
    cfg_write(cnv3_pkg::REG_IMAGE_HEIGHT, geom_word(3));
    for (i = 0; i < 9; i++)
      send_pixel(i == 4 ? 32'h5AA5_C33C : (i[0] ? 32'hFFFF_FFFF : 32'h0000_0000));
    finish_burst();

    // largest positive taps saturate high, geometry below range, spare index ignored
    cfg_write(cnv3_pkg::REG_KERNEL_TOP, CFG_DATA_W'({3{16'h7FFF}}));
    cfg_write(cnv3_pkg::REG_KERNEL_MID, CFG_DATA_W'({3{16'h7FFF}}));
    cfg_write(cnv3_pkg::REG_KERNEL_BOTTOM, CFG_DATA_W'({3{16'h7FFF}}));
    cfg_write(REG_SPARE_FIRST, CFG_DATA_W'({$urandom, $urandom}));
    cfg_write(cnv3_pkg::REG_IMAGE_WIDTH, geom_word(0));
    cfg_write(cnv3_pkg::REG_IMAGE_HEIGHT, geom_word(1));
    for (i = 0; i < 9; i++)
      send_pixel(i == 4 ? 32'h80FF_FFFF : 32'hFFFF_FFFF);
    finish_burst();

    // most negative taps clamp to zero
    cfg_write(cnv3_pkg::REG_KERNEL_TOP, CFG_DATA_W'({3{16'h8000}}));
    cfg_write(cnv3_pkg::REG_KERNEL_MID, CFG_DATA_W'({3{16'h8000}}));
    cfg_write(cnv3_pkg::REG_KERNEL_BOTTOM, CFG_DATA_W'({3{16'h8000}}));
    for (i = 0; i < 9; i++)
      send_pixel($urandom);
    finish_burst();

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      in_idle_pct  = (phase >= 5 && phase <= 8) ? 0 : 12;
      out_idle_pct = in_idle_pct;
      for (k = 0; k < 3; k++) begin
        if (phase == 1 || $urandom_range(0, 2) != 0) begin
          for (t = 0; t < 3; t++) begin
            case ($urandom_range(0, 7))
              0:       tap = 16'h7FFF;
              1:       tap = 16'h8000;
              2:       tap = '0;
              3:       tap = 16'h0100;
              4, 5:    tap = WEIGHT_W'(int'($urandom_range(0, 160)) - 64);
              default: tap = WEIGHT_W'($urandom);
            endcase
            krow[WEIGHT_W*t +: WEIGHT_W] = tap;
          end
          cfg_write(CFG_IDX_W'(cnv3_pkg::REG_KERNEL_TOP + k), CFG_DATA_W'(krow));
        end
      end
      if ($urandom_range(0, 3) == 0)
        cfg_write(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, SPARE_COUNT - 1)),
                  CFG_DATA_W'({$urandom, $urandom}));

      if (phase == WIDE_PHASE) begin
        // over-range width saturates to the widest row, part of its first row only
        cfg_write(cnv3_pkg::REG_IMAGE_WIDTH, geom_word(GEOM_MAX_RAW));
        cfg_write(cnv3_pkg::REG_IMAGE_HEIGHT, geom_word(3));
        n = $urandom_range(stim_width / 8, stim_width / 4);
      end else begin
        geom_pick = $urandom_range(0, 9);
        if (phase == 1 || phase == WIDE_PHASE + 1 || geom_pick < 7)
          cfg_write(cnv3_pkg::REG_IMAGE_WIDTH,
                    geom_word(geom_pick == 0 ? $urandom_range(0, 2) : $urandom_range(3, 14)));
        if (phase == 1 || phase == WIDE_PHASE + 1 || geom_pick < 5 || geom_pick == 9)
          cfg_write(cnv3_pkg::REG_IMAGE_HEIGHT,
                    geom_word(geom_pick == 9 ?
                              $urandom_range(cnv3_pkg::MAX_HEIGHT_DEF + 1, GEOM_MAX_RAW) :
                              geom_pick == 1 ? $urandom_range(0, 2) : $urandom_range(3, 10)));
        if (stim_height > 16) begin
          n = stim_width * $urandom_range(3, 12) + $urandom_range(0, stim_width - 1);
        end else begin
          n = stim_width * stim_height * $urandom_range(1, 3);
          // cut a frame short so the next geometry write restarts mid-frame
          if ($urandom_range(0, 3) == 0)
            n += $urandom_range(1, stim_width * stim_height - 1);
        end
      end

      repeat (n) send_pixel($urandom);
      random_sent += n;
      finish_burst();
    end

    $display("streamed %0d pixels in %0d register phases, %0d filtered pixels compared",
             pixels_sent, phase, checked_total);
    $display("frames from 3x3 to 14x10, a partial 2048-pixel row, extreme taps, restarts");
    if (fail_total == 0 && due_total == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d pixels still due", fail_total, due_total);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== conv3x3_rgba_clamp.f =====
rtl/cnv3_pkg.sv
rtl/cnv3_in_if.sv
rtl/cnv3_out_if.sv
rtl/conv3x3_rgba_clamp.sv
bench/conv3x3_rgba_clamp_checker.sv
bench/conv3x3_rgba_clamp_tb.sv
